// File: rtl/core/mbss_pkg.sv
// Package for the masked byte signature scanner: sizes, register indexes and helpers.
package mbss_pkg;

    // Window depth and address width of the scanned range
    localparam int PATTERN_BYTES = 16;
    localparam int ADDRESS_BITS  = 48;

    // Pattern registers hold at most 16 bytes
    localparam int PAT_CAP   = (PATTERN_BYTES < 16) ? PATTERN_BYTES : 16;
    localparam int LEN_W     = 5;
    localparam int FILL_W    = $clog2(PATTERN_BYTES + 1);
    localparam int WIN_IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    // Stream word widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((8 + ADDRESS_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ADDRESS_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_PATTERN_LEN  = 3'd3
    } cfg_reg_t;

    localparam logic [15:0]      CARE_MASK_RESET = 16'hFFFF;
    localparam logic [LEN_W-1:0] PAT_LEN_RESET   = 5'd1;

    typedef logic [ADDRESS_BITS-1:0] addr_t;
    typedef logic [7:0]              byte_t;

endpackage

// File: rtl/core/masked_byte_signature_scanner.sv
// Top level of the masked byte signature scanner: window, masked compare, result register.
//
// Scans a byte stream for the leftmost occurrence of a signature of up to 16
// bytes, where care-mask bit 0 marks a wildcard byte. One byte is accepted
// every cycle while the result register is empty or being drained. The path
// from the input port through the window shift, the parallel masked compare
// and the start-address subtract into the result register has a single
// register stage. A scan opens with first_byte (after reset a scan counts as
// open); it yields one result: found=1 with the start address (newest address
// minus length plus one) at the first match, or found=0 with address 0 on the
// last byte when nothing matched. Bytes after a finished scan only shift the
// window. Configuration must be written only while idle (not enforced).
module masked_byte_signature_scanner (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [mbss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Byte stream in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mbss_pkg::S_TDATA_W-1:0]     s_tdata,   // data_byte, byte_address
    input  logic                               s_tlast,   // last_byte
    input  logic                               s_tuser,   // first_byte
    // Result out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mbss_pkg::M_TDATA_W-1:0]     m_tdata,   // match_address
    output logic                               m_tuser    // found
);
    import mbss_pkg::*;

    // Configuration registers
    logic [63:0]      pat_low_reg;
    logic [63:0]      pat_high_reg;
    logic [15:0]      care_reg;
    logic [LEN_W-1:0] pat_len_reg;

    // Scan state
    byte_t             win_reg [PATTERN_BYTES];
    byte_t             win_next [PATTERN_BYTES];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              reported_reg, reported_next;

    // Result register
    logic     out_valid_reg, out_valid_next;
    logic     out_found_reg, out_found_next;
    addr_t    out_addr_reg, out_addr_next;

    logic             accept;
    byte_t            in_byte;
    addr_t            in_addr;
    logic             in_first;
    logic             in_last;
    logic [LEN_W-1:0] len_eff;
    logic [127:0]     pat_all;
    logic             match;
    logic [FILL_W-1:0] fill_base;
    logic             reported_base;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_byte  = s_tdata[7:0];
    assign in_addr  = s_tdata[8 +: ADDRESS_BITS];
    assign in_first = s_tuser;
    assign in_last  = s_tlast;
    assign pat_all  = {pat_high_reg, pat_low_reg};

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= CARE_MASK_RESET;
            pat_len_reg  <= PAT_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_wdata[63:0];
                REG_PATTERN_HIGH: pat_high_reg <= cfg_wdata[63:0];
                REG_CARE_MASK:    care_reg     <= cfg_wdata[15:0];
                REG_PATTERN_LEN:  pat_len_reg  <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective pattern length: zero counts as one, saturate at capacity
    always_comb begin
        priority if (pat_len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (pat_len_reg > LEN_W'(PAT_CAP)) begin
            len_eff = LEN_W'(PAT_CAP);
        end else begin
            len_eff = pat_len_reg;
        end
    end

    // Window shift; a first word restarts the fill count and reported flag
    always_comb begin
        fill_base     = in_first ? '0 : fill_reg;
        reported_base = in_first ? 1'b0 : reported_reg;
        win_next[0]   = in_byte;
        for (int j = 1; j < PATTERN_BYTES; j++) begin
            win_next[j] = win_reg[j-1];
        end
        fill_next = (fill_base < FILL_W'(PATTERN_BYTES)) ? fill_base + FILL_W'(1) : fill_base;
    end

    // Masked compare of the newest len_eff bytes against the pattern
    always_comb begin
        logic [LEN_W-1:0] pos;
        match = (32'(fill_next) >= 32'(len_eff));
        for (int i = 0; i < PAT_CAP; i++) begin
            pos = len_eff - LEN_W'(1) - LEN_W'(i);
            if ((LEN_W'(i) < len_eff) && care_reg[i]) begin
                if (win_next[pos[WIN_IDX_W-1:0]] != pat_all[i*8 +: 8]) begin
                    match = 1'b0;
                end
            end
        end
    end

    // Result selection and output register hand-off
    always_comb begin
        reported_next  = reported_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_addr_next  = out_addr_reg;
        if (accept) begin
            reported_next = reported_base;
            if (!reported_base && (match || in_last)) begin
                reported_next  = 1'b1;
                out_valid_next = 1'b1;
                out_found_next = match;
                out_addr_next  = match ? in_addr - ADDRESS_BITS'(len_eff - LEN_W'(1)) : '0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg <= fill_next;
            end
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
        out_found_reg <= out_found_next;
        out_addr_reg  <= out_addr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = M_TDATA_W'(out_addr_reg);

endmodule

// File: rtl/core/mbss_checker.sv
// Port-level checker for the masked byte signature scanner, bound to the top level.
module mbss_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mbss_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import mbss_pkg::*;

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Not-found results carry address zero
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result with nonzero address");

    // An empty result register never stalls the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A new result follows an accepted input word
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an accepted word");

    // Reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind masked_byte_signature_scanner mbss_checker u_mbss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
